// ----- rtl/qxmm_pkg.sv -----
// Shared types and constants for the quad X motor mixer.
package qxmm_pkg;

    localparam int SPEED_W = 10;
    localparam int CORR_W  = 12;
    localparam int SUM_W   = 15;
    localparam int STEP_W  = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int MOTORS  = 4;

    typedef logic [SPEED_W-1:0]               t_speed;
    typedef logic [MOTORS-1:0][SPEED_W-1:0]   t_speed_vec;
    typedef logic signed [CORR_W-1:0]         t_corr;
    typedef logic signed [SUM_W-1:0]          t_sum;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_NORMAL     = 2'd1,
        MODE_FIX_HEIGHT = 2'd2,
        MODE_FAIL       = 2'd3
    } t_mode;

    // Register indexes, byte address 4*i
    localparam logic [1:0] REG_YAW_LIMIT      = 2'd0;
    localparam logic [1:0] REG_SPEED_MAX      = 2'd1;
    localparam logic [1:0] REG_THROTTLE_FLOOR = 2'd2;
    localparam logic [1:0] REG_FAIL_STEP      = 2'd3;

    localparam t_speed             RST_YAW_LIMIT      = 10'd100;
    localparam t_speed             RST_SPEED_MAX      = 10'd700;
    localparam t_speed             RST_THROTTLE_FLOOR = 10'd50;
    localparam logic [STEP_W-1:0]  RST_FAIL_STEP      = 8'd2;

    // Motor order in the speed vector
    localparam int M_FL = 0;
    localparam int M_RL = 1;
    localparam int M_FR = 2;
    localparam int M_RR = 3;

    typedef struct packed {
        t_speed             yaw_limit;
        t_speed             speed_max;
        t_speed             throttle_floor;
        logic [STEP_W-1:0]  fail_step;
    } t_cfg;

endpackage

// ----- rtl/quad_x_motor_mixer_unit.sv -----
// A request accepted into the input register moves on to the result register and shows
// at o_valid, waiting in the input register while the result register is stalled.
// Throughput: one request per cycle while the output is not stalled; the input register,
// the mix logic and the result register form a two-stage pipeline, and the stored speeds
// update as a request leaves the input register, so the next request sees them at once.
// Reset: registers return to their defaults, stored speeds clear to zero, pipeline empties.
module quad_x_motor_mixer_unit
    import qxmm_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_flight_mode,
    input  logic [SPEED_W-1:0]          i_throttle,
    input  logic signed [CORR_W-1:0]    i_pitch_correction,
    input  logic signed [CORR_W-1:0]    i_roll_correction,
    input  logic signed [CORR_W-1:0]    i_yaw_correction,
    input  logic signed [CORR_W-1:0]    i_height_correction,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [SPEED_W-1:0]          o_front_left_speed,
    output logic [SPEED_W-1:0]          o_rear_left_speed,
    output logic [SPEED_W-1:0]          o_front_right_speed,
    output logic [SPEED_W-1:0]          o_rear_right_speed,
    output logic                        o_ramp_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    output logic [DATA_W-1:0]           prdata,
    output logic                        pready
);

    t_cfg       cfg;
    logic       r_in_valid;
    t_mode      r_mode;
    t_speed     r_throttle;
    t_corr      r_pitch;
    t_corr      r_roll;
    t_corr      r_yaw;
    t_corr      r_height;
    t_speed_vec r_speeds;
    logic       r_out_valid;
    t_speed_vec r_out_speeds;
    logic       r_out_done;
    t_speed_vec mix_speeds;
    logic       mix_done;
    logic       out_free;
    logic       advance;
    logic       take;

    qxmm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    qxmm_mix u_mix (
        .i_cfg       (cfg),
        .i_mode      (r_mode),
        .i_throttle  (r_throttle),
        .i_pitch     (r_pitch),
        .i_roll      (r_roll),
        .i_yaw       (r_yaw),
        .i_height    (r_height),
        .i_speeds    (r_speeds),
        .o_speeds    (mix_speeds),
        .o_ramp_done (mix_done)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign take     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_speeds    <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_speeds    <= mix_speeds;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_mode     <= t_mode'(i_flight_mode);
            r_throttle <= i_throttle;
            r_pitch    <= i_pitch_correction;
            r_roll     <= i_roll_correction;
            r_yaw      <= i_yaw_correction;
            r_height   <= i_height_correction;
        end
        if (advance) begin
            r_out_speeds <= mix_speeds;
            r_out_done   <= mix_done;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_front_left_speed  = r_out_speeds[M_FL];
    assign o_rear_left_speed   = r_out_speeds[M_RL];
    assign o_front_right_speed = r_out_speeds[M_FR];
    assign o_rear_right_speed  = r_out_speeds[M_RR];
    assign o_ramp_done         = r_out_done;

endmodule

// ----- rtl/qxmm_cfg.sv -----
// APB register file holding the mixer limits.
module qxmm_cfg
    import qxmm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_YAW_LIMIT:      n_cfg.yaw_limit      = pwdata[SPEED_W-1:0];
                REG_SPEED_MAX:      n_cfg.speed_max      = pwdata[SPEED_W-1:0];
                REG_THROTTLE_FLOOR: n_cfg.throttle_floor = pwdata[SPEED_W-1:0];
                REG_FAIL_STEP:      n_cfg.fail_step      = pwdata[STEP_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_YAW_LIMIT:      prdata = {{(DATA_W-SPEED_W){1'b0}}, r_cfg.yaw_limit};
            REG_SPEED_MAX:      prdata = {{(DATA_W-SPEED_W){1'b0}}, r_cfg.speed_max};
            REG_THROTTLE_FLOOR: prdata = {{(DATA_W-SPEED_W){1'b0}}, r_cfg.throttle_floor};
            REG_FAIL_STEP:      prdata = {{(DATA_W-STEP_W){1'b0}}, r_cfg.fail_step};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yaw_limit      <= RST_YAW_LIMIT;
            r_cfg.speed_max      <= RST_SPEED_MAX;
            r_cfg.throttle_floor <= RST_THROTTLE_FLOOR;
            r_cfg.fail_step      <= RST_FAIL_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/qxmm_mix.sv -----
// Mixing, fail ramp and clamping for one control tick.
module qxmm_mix
    import qxmm_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_mode      i_mode,
    input  t_speed     i_throttle,
    input  t_corr      i_pitch,
    input  t_corr      i_roll,
    input  t_corr      i_yaw,
    input  t_corr      i_height,
    input  t_speed_vec i_speeds,
    output t_speed_vec o_speeds,
    output logic       o_ramp_done
);

    t_sum thr_s;
    t_sum pit_s;
    t_sum rol_s;
    t_sum yaw_s;
    t_sum hgt_s;
    t_sum lim_s;
    t_sum max_s;
    t_sum y_s;
    t_sum h_s;
    t_sum step_s;
    t_sum raw [MOTORS];
    logic done;
    logic below_floor;

    always_comb begin
        thr_s  = t_sum'({{(SUM_W-SPEED_W){1'b0}}, i_throttle});
        pit_s  = t_sum'({{(SUM_W-CORR_W){i_pitch[CORR_W-1]}}, i_pitch});
        rol_s  = t_sum'({{(SUM_W-CORR_W){i_roll[CORR_W-1]}}, i_roll});
        yaw_s  = t_sum'({{(SUM_W-CORR_W){i_yaw[CORR_W-1]}}, i_yaw});
        hgt_s  = t_sum'({{(SUM_W-CORR_W){i_height[CORR_W-1]}}, i_height});
        lim_s  = t_sum'({{(SUM_W-SPEED_W){1'b0}}, i_cfg.yaw_limit});
        max_s  = t_sum'({{(SUM_W-SPEED_W){1'b0}}, i_cfg.speed_max});
        step_s = t_sum'({{(SUM_W-STEP_W){1'b0}}, i_cfg.fail_step});

        // symmetric yaw clamp
        if (yaw_s > lim_s) begin
            y_s = lim_s;
        end else if (yaw_s < -lim_s) begin
            y_s = -lim_s;
        end else begin
            y_s = yaw_s;
        end
        h_s = (i_mode == MODE_FIX_HEIGHT) ? hgt_s : '0;

        done = 1'b0;
        case (i_mode)
            MODE_IDLE: begin
                for (int i = 0; i < MOTORS; i++) raw[i] = '0;
            end
            MODE_NORMAL, MODE_FIX_HEIGHT: begin
                raw[M_FL] = thr_s + pit_s - rol_s + y_s + h_s;
                raw[M_RL] = thr_s - pit_s - rol_s - y_s + h_s;
                raw[M_FR] = thr_s + pit_s + rol_s - y_s + h_s;
                raw[M_RR] = thr_s - pit_s + rol_s + y_s + h_s;
            end
            MODE_FAIL: begin
                for (int i = 0; i < MOTORS; i++) begin
                    raw[i] = t_sum'({{(SUM_W-SPEED_W){1'b0}}, i_speeds[i]}) - step_s;
                end
                done = (raw[M_FL] <= 0) && (raw[M_RL] <= 0)
                    && (raw[M_FR] <= 0) && (raw[M_RR] <= 0);
            end
            default: begin
                for (int i = 0; i < MOTORS; i++) raw[i] = '0;
            end
        endcase

        below_floor = (i_throttle < i_cfg.throttle_floor);

        for (int i = 0; i < MOTORS; i++) begin
            if (below_floor || raw[i] < 0) begin
                o_speeds[i] = '0;
            end else if (raw[i] > max_s) begin
                o_speeds[i] = i_cfg.speed_max;
            end else begin
                o_speeds[i] = raw[i][SPEED_W-1:0];
            end
        end
        o_ramp_done = done;
    end

endmodule
